// ===== hw/rtl/ssc_pkg.sv =====
// Shared types, constants and the hall-to-phase table for the six-step
// commutation block. No dependencies.
`default_nettype none

package ssc_pkg;

  localparam int unsigned HALL_W     = 3;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned RAMP_W     = 10;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP     = 3'd4;

  // register reset values
  localparam logic [RAMP_W-1:0] RST_RAMP_INTERVAL = 10'd50;
  localparam logic [DUTY_W-1:0] RST_COARSE_STEP   = 16'd100;
  localparam logic [DUTY_W-1:0] RST_FINE_STEP     = 16'd10;

  // phase modes
  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HI_PWM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LO_ON  = 2'd2;

  localparam logic [HALL_W-1:0] HALL_1 = 3'd1;
  localparam logic [HALL_W-1:0] HALL_2 = 3'd2;
  localparam logic [HALL_W-1:0] HALL_3 = 3'd3;
  localparam logic [HALL_W-1:0] HALL_4 = 3'd4;
  localparam logic [HALL_W-1:0] HALL_5 = 3'd5;
  localparam logic [HALL_W-1:0] HALL_6 = 3'd6;

  typedef struct packed {
    logic [HALL_W-1:0] hall_code;
    logic [DUTY_W-1:0] target_duty;
    logic              fault_any;
    logic              start_press;
    logic              stop_request;
  } ssc_in_t;

  typedef struct packed {
    logic [MODE_W-1:0] phase_u_mode;
    logic [MODE_W-1:0] phase_v_mode;
    logic [MODE_W-1:0] phase_w_mode;
    logic [DUTY_W-1:0] duty_out;
    logic              running;
  } ssc_out_t;

  typedef struct packed {
    logic              direction;
    logic [DUTY_W-1:0] min_duty;
    logic [RAMP_W-1:0] ramp_interval;
    logic [DUTY_W-1:0] coarse_step;
    logic [DUTY_W-1:0] fine_step;
  } ssc_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] u;
    logic [MODE_W-1:0] v;
    logic [MODE_W-1:0] w;
  } ssc_phase_t;

  // Reverse direction walks the forward table mirrored: code h maps to 7-h.
  function automatic ssc_phase_t phase_lookup(input logic dir,
                                              input logic [HALL_W-1:0] hall);
    logic [HALL_W-1:0] h;
    ssc_phase_t        p;
    h = dir ? ~hall : hall;
    unique case (h)
      HALL_1:  p = '{u: MODE_OFF,    v: MODE_LO_ON,  w: MODE_HI_PWM};
      HALL_2:  p = '{u: MODE_LO_ON,  v: MODE_HI_PWM, w: MODE_OFF};
      HALL_3:  p = '{u: MODE_LO_ON,  v: MODE_OFF,    w: MODE_HI_PWM};
      HALL_4:  p = '{u: MODE_HI_PWM, v: MODE_OFF,    w: MODE_LO_ON};
      HALL_5:  p = '{u: MODE_HI_PWM, v: MODE_LO_ON,  w: MODE_OFF};
      HALL_6:  p = '{u: MODE_OFF,    v: MODE_HI_PWM, w: MODE_LO_ON};
      default: p = '{u: MODE_OFF,    v: MODE_OFF,    w: MODE_OFF};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssc_cfg.sv =====
// Configuration register file for the six-step commutation block.
// Depends on ssc_pkg.
`default_nettype none

module ssc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ssc_pkg::ssc_cfg_t                   cfg
);
  import ssc_pkg::*;

  ssc_cfg_t cfg_r;
  ssc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION:     cfg_nxt.direction     = cfg_wdata[0];
        CFG_MIN_DUTY:      cfg_nxt.min_duty      = cfg_wdata[DUTY_W-1:0];
        CFG_RAMP_INTERVAL: cfg_nxt.ramp_interval = cfg_wdata[RAMP_W-1:0];
        CFG_COARSE_STEP:   cfg_nxt.coarse_step   = cfg_wdata[DUTY_W-1:0];
        CFG_FINE_STEP:     cfg_nxt.fine_step     = cfg_wdata[DUTY_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction     <= 1'b0;
      cfg_r.min_duty      <= '0;
      cfg_r.ramp_interval <= RST_RAMP_INTERVAL;
      cfg_r.coarse_step   <= RST_COARSE_STEP;
      cfg_r.fine_step     <= RST_FINE_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_core.sv =====
// Run/stop control, duty ramp and commutation lookup for one tick word.
// Holds the run flag, duty and ramp countdown. Depends on ssc_pkg.
`default_nettype none

module ssc_core #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire ssc_pkg::ssc_cfg_t cfg,
  input  wire ssc_pkg::ssc_in_t  word,
  output ssc_pkg::ssc_out_t      result
);
  import ssc_pkg::*;

  logic                 run_r, run_nxt;
  logic [DUTY_BITS-1:0] duty_r, duty_nxt;
  logic [RAMP_W-1:0]    cnt_r, cnt_nxt;

  logic [DUTY_BITS-1:0] tgt, min_d, duty_a, gap, coarse, fine, ramped;
  logic                 run_a, up;
  logic [RAMP_W-1:0]    cnt_a;
  ssc_phase_t           ph;

  assign tgt    = word.target_duty[DUTY_BITS-1:0];
  assign min_d  = cfg.min_duty[DUTY_BITS-1:0];
  assign coarse = cfg.coarse_step[DUTY_BITS-1:0];
  assign fine   = cfg.fine_step[DUTY_BITS-1:0];

  // start / stop decision
  always_comb begin
    run_a  = run_r;
    duty_a = duty_r;
    cnt_a  = cnt_r;
    if (!run_r) begin
      if (!word.fault_any && (tgt != '0) && word.start_press) begin
        run_a  = 1'b1;
        duty_a = min_d;
        cnt_a  = cfg.ramp_interval;
      end
    end else if (word.stop_request || (tgt == '0)) begin
      run_a  = 1'b0;
      duty_a = min_d;
    end
  end

  // one ramp step toward the target; never overshoots
  assign up  = (tgt >= duty_a);
  assign gap = up ? DUTY_BITS'(tgt - duty_a) : DUTY_BITS'(duty_a - tgt);

  always_comb begin
    if (DUTY_W'(gap) > cfg.coarse_step) begin
      ramped = up ? DUTY_BITS'(duty_a + coarse) : DUTY_BITS'(duty_a - coarse);
    end else if (DUTY_W'(gap) > cfg.fine_step) begin
      ramped = up ? DUTY_BITS'(duty_a + fine) : DUTY_BITS'(duty_a - fine);
    end else begin
      ramped = tgt;
    end
  end

  always_comb begin
    duty_nxt = duty_a;
    cnt_nxt  = cnt_a;
    run_nxt  = run_a;
    if (run_a) begin
      if (cnt_a == '0) begin
        cnt_nxt  = cfg.ramp_interval;
        duty_nxt = ramped;
      end else begin
        cnt_nxt = cnt_a - 1'b1;
      end
    end
  end

  always_comb begin
    ph = phase_lookup(cfg.direction, word.hall_code);
    result.phase_u_mode = run_nxt ? ph.u : MODE_OFF;
    result.phase_v_mode = run_nxt ? ph.v : MODE_OFF;
    result.phase_w_mode = run_nxt ? ph.w : MODE_OFF;
    result.duty_out     = DUTY_W'(duty_nxt);
    result.running      = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      duty_r <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      run_r  <= run_nxt;
      duty_r <= duty_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/six_step_commutation_duty_ramp.sv =====
// Six-step hall commutation with ramped duty: input and result registers
// around the per-tick update. Depends on ssc_pkg, ssc_cfg, ssc_core.
//
// One tick word in gives one result word out. A word is registered on
// acceptance, updated in a single pass through the run/stop, ramp and hall
// table logic, and lands in the result register once that register can take it.
// One word is taken every cycle while the result register can advance;
// the rate is set by the update of the run flag, duty and ramp countdown
// that each tick leaves for the next. While a result waits for out_ready
// the input register still takes one more word. Configuration writes take
// effect at the next edge and belong between bursts, with no word in flight.
`default_nettype none

module six_step_commutation_duty_ramp #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire ssc_pkg::ssc_in_t               in_word,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output ssc_pkg::ssc_out_t                   out_word,
  input  wire logic                           cfg_we,
  input  wire logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ssc_pkg::*;

  ssc_cfg_t cfg;
  ssc_in_t  in_word_r;
  ssc_out_t out_word_r;
  ssc_out_t result;
  logic     in_vld_r, out_vld_r, adv;

  ssc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssc_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .cfg    (cfg),
    .word   (in_word_r),
    .result (result)
  );

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_word;
    end
    if (adv) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_word_r))
    else $error("pending tick word dropped or changed");

  a_stopped_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_word_r.running |->
      out_word_r.phase_u_mode == MODE_OFF && out_word_r.phase_v_mode == MODE_OFF &&
      out_word_r.phase_w_mode == MODE_OFF)
    else $error("phases driven while stopped");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed word produced no result");
`endif

endmodule

`default_nettype wire
